// File: rtl/lff_pkg.sv
// ----------------------------------------------------------------------------
// lff_pkg: shared types and constants of the LED frame packet framer
// Frame length, preamble and tail tables, and the command queued between
// the front and back halves.
// ----------------------------------------------------------------------------
package lff_pkg;

    localparam int LED_COUNT = 144;               // LEDs per frame, 2..255
    localparam int PRE_LEN   = 13;
    localparam int TAIL_LEN  = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int STEP_W = 4;                    // holds 0..PRE_LEN

    // step codes of the back sequencer
    localparam logic [STEP_W-1:0] STEP_PRE_BYTE = STEP_W'(PRE_LEN);
    localparam logic [STEP_W-1:0] STEP_CSUM     = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_TAIL0    = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_TAIL_END = STEP_W'(1 + TAIL_LEN);

    localparam logic [7:0] LAST_POS = 8'(LED_COUNT - 1);
    localparam logic [7:0] TAIL_END = 8'h5D;

    typedef struct packed {
        logic [7:0] data;      // brightness byte
        logic [7:0] csum;      // running sum including this byte
        logic       first;     // first byte of frame, preamble goes ahead
        logic       last;      // last byte of frame, checksum and tail follow
    } lff_cmd_t;

    typedef struct packed {
        logic     valid;
        lff_cmd_t cmd;
    } lff_head_t;

    function automatic logic [7:0] preamble_byte(input logic [STEP_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h5A;
            4'd1:    b = 8'hFF;
            4'd2:    b = 8'h01;
            4'd3:    b = 8'h5A;
            4'd4:    b = 8'h24;
            4'd5:    b = 8'h21;
            4'd6:    b = 8'h3D;
            4'd7:    b = 8'h01;
            4'd8:    b = 8'h83;
            4'd9:    b = 8'h5A;
            4'd10:   b = 8'hFF;
            4'd11:   b = 8'h02;
            4'd12:   b = 8'h5B;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h5A;
            2'd1: b = 8'hFF;
            2'd2: b = 8'h04;
            2'd3: b = TAIL_END;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/lff_front.sv
// ----------------------------------------------------------------------------
// lff_front: request intake and classification
// Tracks frame position and running sum, tags each byte as first, middle or
// last and pushes a command into the queue.
// ----------------------------------------------------------------------------
module lff_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        brightness,
    input  logic              q_full,
    output logic              push,
    output lff_pkg::lff_cmd_t push_cmd
);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic       is_first;
    logic       is_last;
    logic [7:0] sum_new;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign is_first = (pos_reg == 8'd0);
    assign is_last  = (pos_reg >= lff_pkg::LAST_POS);   // past the end closes too
    assign sum_new  = (is_first ? 8'd0 : sum_reg) + brightness;

    always_comb
    begin
        push_cmd.data  = brightness;
        push_cmd.csum  = sum_new;
        push_cmd.first = is_first;
        push_cmd.last  = is_last;
    end

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (push)
        begin
            if (is_last)
            begin
                pos_next = 8'd0;
                sum_next = 8'd0;
            end
            else
            begin
                pos_next = pos_reg + 8'd1;
                sum_next = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'd0;
            sum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

endmodule

// File: rtl/lff_fifo.sv
// ----------------------------------------------------------------------------
// lff_fifo: command queue between front and back
// Small register queue with head look-ahead.
// ----------------------------------------------------------------------------
module lff_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lff_pkg::lff_cmd_t  push_cmd,
    output logic               full,
    input  logic               pop,
    output lff_pkg::lff_head_t head
);

    lff_pkg::lff_cmd_t                 mem_reg [lff_pkg::FIFO_DEPTH];
    logic [lff_pkg::FIFO_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [lff_pkg::FIFO_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [lff_pkg::FIFO_CW-1:0]       cnt_reg, cnt_next;
    logic                              do_pop;

    assign full       = (cnt_reg == lff_pkg::FIFO_CW'(lff_pkg::FIFO_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + lff_pkg::FIFO_CW'(push) - lff_pkg::FIFO_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/lff_back.sv
// ----------------------------------------------------------------------------
// lff_back: packet byte sequencer
// Expands the head command into its byte run, one byte per cycle while the
// output register is free or being taken, into a registered output stage.
// ----------------------------------------------------------------------------
module lff_back (
    input  logic               clk,
    input  logic               rst_n,
    input  lff_pkg::lff_head_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               frame_done
);

    logic [lff_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg;
    logic                       run_last_reg;
    logic                       frame_done_reg;
    logic                       load;
    logic [7:0]                 gen_byte;
    logic                       gen_final;
    logic                       gen_done;
    logic [lff_pkg::STEP_W-1:0] tail_idx;

    assign tail_idx = step_reg - lff_pkg::STEP_TAIL0;

    always_comb
    begin
        gen_byte  = head.cmd.data;
        gen_final = 1'b0;
        gen_done  = 1'b0;
        priority if (head.cmd.first)
        begin
            if (step_reg == lff_pkg::STEP_PRE_BYTE)
            begin
                gen_final = 1'b1;
            end
            else
            begin
                gen_byte = lff_pkg::preamble_byte(step_reg);
            end
        end
        else if (head.cmd.last)
        begin
            if (step_reg == lff_pkg::STEP_CSUM)
            begin
                gen_byte = head.cmd.csum;
            end
            else if (step_reg >= lff_pkg::STEP_TAIL0)
            begin
                gen_byte = lff_pkg::tail_byte(tail_idx[1:0]);
                gen_final = (step_reg == lff_pkg::STEP_TAIL_END);
                gen_done  = gen_final;
            end
        end
        else
        begin
            gen_final = 1'b1;
        end
    end

    assign load = head.valid && (!out_valid_reg || out_ready);
    assign pop  = load && gen_final;

    always_comb
    begin
        step_next = step_reg;
        if (pop)
        begin
            step_next = '0;
        end
        else if (load)
        begin
            step_next = step_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= gen_byte;
            run_last_reg   <= gen_final;
            frame_done_reg <= gen_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign frame_done = frame_done_reg;

endmodule

// File: rtl/led_frame_packet_framer.sv
// ----------------------------------------------------------------------------
// led_frame_packet_framer: LED frame packet framer, top level
// Turns a stream of brightness requests into the controller's byte stream:
// preamble, pixel bytes, checksum and tail.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | handshake
//  --------+----------------------------------+-----------+-----------------
//  input   | brightness[7:0]                  | in        | in_valid/in_ready
//  output  | out_byte[7:0] run_last frame_done| out       | out_valid/out_ready
//
// Bytes: the back sequencer emits one byte per cycle unless out_ready stalls
// it; a middle byte yields only itself, the first byte of a frame the
// preamble plus byte, the last byte the byte, checksum and four tail bytes.
// A four-entry command queue lets the front keep taking requests while the
// back is busy with a preamble or tail burst.
// Reset: rst_n clears frame position, running sum, queue and output valid.
// Stalls: in_ready drops only when the queue is full; out_ready low while
// out_valid is high holds the output register and stops the sequencer.
// ----------------------------------------------------------------------------
module led_frame_packet_framer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] brightness,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_done
);

    lff_pkg::lff_cmd_t  push_cmd;
    lff_pkg::lff_head_t head;
    logic               push;
    logic               pop;
    logic               q_full;

    // front: position tracking, checksum accumulation, classification
    lff_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .brightness (brightness),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // queue decoupling intake from byte emission
    lff_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    // back: expands each command into its run of bytes
    lff_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

    // frame end always closes a run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> run_last)
        else $error("frame_done without run_last");

    // frame end carries the final tail byte
    a_done_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (out_byte == lff_pkg::TAIL_END))
        else $error("frame_done on wrong byte");

    // a command is never both first and last of a frame
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> !(head.cmd.first && head.cmd.last))
        else $error("command tagged first and last");

    // intake and queue agree on flow control
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (in_valid && in_ready && !q_full))
        else $error("push without accepted request");

endmodule

// File: tb/sv/tb_led_frame_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_frame_packet_framer: self-checking bench for the LED frame framer
// Feeds brightness requests through a valid/ready driver and scores every
// stream byte (data, run_last, frame_done) against an in-bench frame model.
// Both sides idle at random. The sender drains the block between phases.
// ----------------------------------------------------------------------------
module tb_led_frame_packet_framer;

    localparam int  LED_COUNT   = lff_pkg::LED_COUNT;
    localparam int  PRE_LEN     = lff_pkg::PRE_LEN;
    localparam int  TAIL_LEN    = lff_pkg::TAIL_LEN;

    localparam real CLK_PERIOD  = 12.0;
    localparam int  RESET_CYC   = 7;
    localparam int  IDLE_PCT    = 34;       // idle chance per cycle, each side
    localparam int  SETTLE_CYC  = 20;       // quiet cycles after the last byte
    localparam int  RUN_LIMIT   = 200_000;  // cycles before the watchdog fires
    localparam int  TOTAL_REQS  = 330;
    localparam int  DIRECT_REQS = 24;

    // controller preamble and tail, first byte in the top bits
    localparam logic [PRE_LEN*8-1:0] PREAMBLE_SEQ = {
        8'h5A, 8'hFF, 8'h01, 8'h5A, 8'h24, 8'h21, 8'h3D,
        8'h01, 8'h83, 8'h5A, 8'hFF, 8'h02, 8'h5B
    };
    localparam logic [TAIL_LEN*8-1:0] TAIL_SEQ = {8'h5A, 8'hFF, 8'h04, 8'h5D};

    // directed levels: extremes, single bits set, single bits clear, mixed patterns
    localparam logic [DIRECT_REQS*8-1:0] DIRECT_LEVELS = {
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
        8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hFD, 8'hFB,
        8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'hC3, 8'h3C, 8'hFF, 8'h00
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } stream_byte_t;

    // DUT signals; the inputs hold a known value from time zero
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] brightness = 8'h00;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;

    // bench state
    logic [7:0]   pending_levels [$];   // requests not yet offered
    stream_byte_t expected_stream [$];  // predicted bytes, oldest first
    logic [7:0]   led_pos   = 8'h00;    // model of the frame position
    logic [7:0]   pixel_sum = 8'h00;    // model of the running checksum
    logic         steady    = 1'b0;     // suppresses idling on both sides
    int           errors    = 0;
    int           reqs_taken    = 0;
    int           frames_closed = 0;
    int           bytes_checked = 0;

    led_frame_packet_framer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    // Frame model: appends the bytes one accepted request produces.
    // First byte of a frame brings the preamble along; the last one (or any
    // position at or past the end) closes with checksum and tail.
    function void build_packet_bytes(input logic [7:0] level);
        stream_byte_t sb;
        if (led_pos == 8'h00)
        begin
            for (int i = 0; i < PRE_LEN; i++)
            begin
                sb = '{PREAMBLE_SEQ[(PRE_LEN-1-i)*8 +: 8], 1'b0, 1'b0};
                expected_stream.push_back(sb);
            end
            pixel_sum = 8'h00;
        end
        pixel_sum = pixel_sum + level;         // wraps at 8 bits
        if (int'(led_pos) + 1 >= LED_COUNT)
        begin
            expected_stream.push_back('{level, 1'b0, 1'b0});
            expected_stream.push_back('{pixel_sum, 1'b0, 1'b0});
            for (int i = 0; i < TAIL_LEN; i++)
            begin
                sb.data = TAIL_SEQ[(TAIL_LEN-1-i)*8 +: 8];
                sb.last = (i == TAIL_LEN - 1);
                sb.done = (i == TAIL_LEN - 1);
                expected_stream.push_back(sb);
            end
            led_pos   = 8'h00;
            pixel_sum = 8'h00;
            frames_closed++;
        end
        else
        begin
            expected_stream.push_back('{level, 1'b1, 1'b0});
            led_pos = led_pos + 8'd1;
        end
    endfunction

    // biased level: extremes come up often so checksums wrap both ways
    function logic [7:0] pick_level();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Driver: offers the next pending request, holds it until taken.
    // Prediction happens at the accepting edge; the output is registered,
    // so no byte of this request can be taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            brightness <= 8'h00;
        end
        else
        begin : drive
            logic       nxt_valid;
            logic [7:0] nxt_level;
            nxt_valid = in_valid;
            nxt_level = brightness;
            if (in_valid && in_ready)
            begin
                build_packet_bytes(brightness);
                reqs_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_levels.size() > 0
                && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt_level = pending_levels.pop_front();
                nxt_valid = 1'b1;
            end
            in_valid   <= nxt_valid;
            brightness <= nxt_level;
        end
    end

    // Monitor: scores each taken byte against the oldest prediction, and
    // applies random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin : score
            stream_byte_t want;
            if (out_valid && out_ready)
            begin
                if (expected_stream.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual %02h last %b done %b",
                             $time, out_byte, run_last, frame_done);
                    errors++;
                end
                else
                begin
                    want = expected_stream.pop_front();
                    bytes_checked++;
                    if (out_byte !== want.data)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.data, out_byte);
                        errors++;
                    end
                    if (run_last !== want.last)
                    begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.last, run_last);
                        errors++;
                    end
                    if (frame_done !== want.done)
                    begin
                        $display("%0t: frame_done expected %b actual %b",
                                 $time, want.done, frame_done);
                        errors++;
                    end
                end
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Hold the sender until every queued request is taken and every
    // predicted byte has come out. Checked at the falling edge, clear of
    // the rising-edge updates.
    task automatic drain_stream();
        do
            @(negedge clk);
        while (pending_levels.size() > 0 || in_valid || expected_stream.size() > 0);
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes and walking bits at the head of frame one
        for (int i = 0; i < DIRECT_REQS; i++)
            pending_levels.push_back(DIRECT_LEVELS[(DIRECT_REQS-1-i)*8 +: 8]);
        drain_stream();

        // rest of frame one, random; it closes with checksum and tail
        for (int i = DIRECT_REQS; i < LED_COUNT; i++)
            pending_levels.push_back(pick_level());
        drain_stream();

        // a whole frame with no idling on either side
        steady = 1'b1;
        for (int i = 0; i < LED_COUNT; i++)
            pending_levels.push_back(pick_level());
        drain_stream();
        steady = 1'b0;

        // remainder: part of a third frame, random idling again
        for (int i = DIRECT_REQS + 2 * LED_COUNT - DIRECT_REQS; i < TOTAL_REQS; i++)
            pending_levels.push_back(pick_level());
        drain_stream();

        // anything the block still emits now is flagged by the monitor
        repeat (SETTLE_CYC) @(negedge clk);

        $display("Run covered %0d brightness requests and %0d closed frames,",
                 reqs_taken, frames_closed);
        $display("with %0d stream bytes scored under random stalls on both sides.",
                 bytes_checked);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT);
        $display("%0t: watchdog expired, %0d bytes still awaited",
                 $time, expected_stream.size());
        $display("Verification failed");
        $finish;
    end

endmodule
